FILE: hw/rtl/jplr_pkg.sv
// Shared types, codes and constants for the joystick panel link receiver.
package jplr_pkg;

  localparam int AXIS_COUNT_DEF = 3;
  localparam int AXES_MAX       = 3;
  localparam int DIV_BITS       = 32;

  localparam logic       OP_POLL   = 1'b0;
  localparam logic       OP_BYTE   = 1'b1;
  localparam logic       KIND_TX   = 1'b0;
  localparam logic       KIND_READ = 1'b1;
  localparam logic [1:0] REQ_CAL   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RECAL = 2'd2;
  localparam logic [1:0] CMD_MOTOR = 2'd3;
  localparam logic [1:0] MOTOR_LAST = 2'd2;
  localparam logic [7:0] FRAME_MIN = 8'd4;

  localparam logic [31:0] AXIS_LIMIT = 32'd1095216660;
  localparam logic [9:0]  SPAN_SCALE = 10'd1000;

  // per axis: four table reads, a setup step, then the divide steps
  localparam logic [5:0] STEP_SETUP = 6'd5;
  localparam logic [5:0] STEP_LAST  = 6'(5 + DIV_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAPTURE,
    ST_REPLY,
    ST_AFTER_CMD,
    ST_FRAME,
    ST_CALC
  } jplr_state_t;

  typedef struct packed {
    logic       take;
    logic       cal_wr;
    logic       cc_clr;
    logic       cc_inc;
    logic       hold_wr;
    logic       last_wr;
    logic       calc_start;
    logic       out_load;
    logic       out_kind;
    logic [1:0] out_tx;
    logic       out_rvalid;
    logic       out_frame;
    logic [1:0] out_motor;
  } jplr_cmd_t;

  typedef struct packed {
    logic       item_valid;
    logic       item_op;
    logic       byte_cmd;
    logic       byte_frame;
    logic [1:0] byte_low;
    logic       cap_last;
    logic       frame_last;
    logic       out_full;
    logic       calc_done;
  } jplr_stat_t;

endpackage

FILE: hw/rtl/jplr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jplr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 12,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/jplr_ctrl.sv
// Link protocol controller: phase state machine, calibration and command flags.
module jplr_ctrl import jplr_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  jplr_stat_t stat,
  output jplr_cmd_t  cmd
);

  localparam bit SINGLE = (AXIS_COUNT == 1);

  jplr_state_t state_r, state_nxt, first_nxt;
  logic        calibrated_r, calibrated_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [1:0]  motors_r, motors_nxt;
  logic        fire;

  assign fire = (state_r != ST_CALC) && stat.item_valid && !stat.out_full;
  assign first_nxt = !stat.byte_frame ? ST_IDLE : (SINGLE ? ST_CALC : ST_FRAME);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CALC: begin
        if (stat.calc_done) state_nxt = ST_IDLE;
      end
      default: begin
        if (fire) begin
          if (stat.item_op == OP_POLL) begin
            if (!calibrated_r || pending_r == CMD_RECAL) state_nxt = ST_CAPTURE;
            else state_nxt = ST_REPLY;
          end else begin
            case (state_r)
              ST_CAPTURE: begin
                if (stat.cap_last) state_nxt = calibrated_r ? ST_REPLY : ST_IDLE;
              end
              ST_REPLY: begin
                state_nxt = stat.byte_cmd ? ST_AFTER_CMD : first_nxt;
              end
              ST_AFTER_CMD: state_nxt = first_nxt;
              ST_FRAME: begin
                if (stat.frame_last) state_nxt = ST_CALC;
              end
              default: state_nxt = state_r;
            endcase
          end
        end
      end
    endcase
  end

  always_comb begin
    calibrated_nxt = calibrated_r;
    pending_nxt    = pending_r;
    motors_nxt     = motors_r;
    if (fire && stat.item_op == OP_POLL && calibrated_r) begin
      pending_nxt = CMD_NONE;
      if (pending_r == CMD_MOTOR) begin
        motors_nxt = (motors_r == MOTOR_LAST) ? 2'd0 : motors_r + 2'd1;
      end
    end
    if (fire && stat.item_op == OP_BYTE) begin
      if (state_r == ST_CAPTURE && stat.cap_last) calibrated_nxt = 1'b1;
      if (state_r == ST_REPLY && stat.byte_cmd) pending_nxt = stat.byte_low;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.out_motor = motors_nxt;
    case (state_r)
      ST_CALC: begin
        if (stat.calc_done) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = KIND_READ;
          cmd.out_rvalid = 1'b1;
          cmd.out_frame  = 1'b1;
        end
      end
      default: begin
        if (fire) begin
          cmd.take = 1'b1;
          if (stat.item_op == OP_POLL) begin
            cmd.cc_clr   = 1'b1;
            cmd.out_kind = KIND_TX;
            if (!calibrated_r) begin
              cmd.out_load = 1'b1;
              cmd.out_tx   = REQ_CAL;
            end else if (pending_r != CMD_RECAL) begin
              cmd.out_load = 1'b1;
              cmd.out_tx   = REQ_READ;
            end
          end else begin
            case (state_r)
              ST_CAPTURE: begin
                cmd.cal_wr = 1'b1;
                if (stat.cap_last) begin
                  cmd.cc_clr = 1'b1;
                  if (calibrated_r) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_TX;
                    cmd.out_tx   = REQ_READ;
                  end
                end else begin
                  cmd.cc_inc = 1'b1;
                end
              end
              ST_REPLY, ST_AFTER_CMD: begin
                if (!(state_r == ST_REPLY && stat.byte_cmd)) begin
                  if (stat.byte_frame) begin
                    if (SINGLE) begin
                      cmd.last_wr    = 1'b1;
                      cmd.cc_clr     = 1'b1;
                      cmd.calc_start = 1'b1;
                    end else begin
                      cmd.hold_wr = 1'b1;
                      cmd.cc_inc  = 1'b1;
                    end
                  end else begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_READ;
                  end
                end
              end
              ST_FRAME: begin
                if (stat.frame_last) begin
                  cmd.last_wr    = 1'b1;
                  cmd.cc_clr     = 1'b1;
                  cmd.calc_start = 1'b1;
                end else begin
                  cmd.hold_wr = 1'b1;
                  cmd.cc_inc  = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      calibrated_r <= 1'b0;
      pending_r    <= CMD_NONE;
      motors_r     <= 2'd0;
    end else begin
      state_r      <= state_nxt;
      calibrated_r <= calibrated_nxt;
      pending_r    <= pending_nxt;
      motors_r     <= motors_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.out_full)
    else $error("result loaded over a waiting result");
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    stat.calc_done |-> state_r == ST_CALC)
    else $error("scaling finished outside calc state");
  a_start_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_start |=> state_r == ST_CALC)
    else $error("scaling started without entering calc state");
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    calibrated_r |=> calibrated_r)
    else $error("calibrated flag dropped");
`endif

endmodule

FILE: hw/rtl/jplr_dp.sv
// Datapath: input buffer, calibration RAM, axis scaler with serial divider, result register.
module jplr_dp import jplr_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [1:0]         out_tx_byte,
  output logic signed [31:0] out_axis_x,
  output logic signed [31:0] out_axis_y,
  output logic signed [31:0] out_axis_z,
  output logic               out_reading_valid,
  output logic [1:0]         out_motor_group,
  output logic               out_span_fault,
  input  jplr_cmd_t          cmd,
  output jplr_stat_t         stat
);

  localparam int DEPTH  = 4 * AXIS_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);

  // input buffer
  logic       ib_valid_r;
  logic       ib_op_r;
  logic [7:0] ib_byte_r;

  logic [ADDR_W-1:0] cc_r;
  logic [7:0]        hold0_r, hold1_r, last_r;

  // scaler sequencing
  logic        busy_r, done_r;
  logic [1:0]  ax_r;
  logic [5:0]  step_r;
  logic [7:0]  cal_sh_r [4];
  logic [7:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;

  logic [17:0] div_r, rem_r;
  logic [31:0] q_r;
  logic        neg_r, dead_r, zero_r;
  logic [31:0] ax_val_r [AXES_MAX];
  logic        fault_r;

  logic [7:0]  a_sel, num;
  logic        below, above, den_neg;
  logic [8:0]  den;
  logic [7:0]  den_mag;
  logic [17:0] div_prod;
  logic [18:0] rem2;
  logic        q_bit;
  logic [31:0] q_fin, val;
  logic        ax_last, step_last;

  // result register
  logic        out_valid_r, out_kind_r, out_rvalid_r, out_fault_r;
  logic [1:0]  out_tx_r, out_motor_r;
  logic [31:0] out_x_r, out_y_r, out_z_r;

  assign in_ready = !ib_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      ib_valid_r <= 1'b1;
    end else if (cmd.take) begin
      ib_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib_op_r   <= in_op;
      ib_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
    end else if (cmd.cc_clr) begin
      cc_r <= '0;
    end else if (cmd.cc_inc) begin
      cc_r <= cc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_wr) begin
      if (cc_r[0]) hold1_r <= ib_byte_r;
      else hold0_r <= ib_byte_r;
    end
    if (cmd.last_wr) last_r <= ib_byte_r;
  end

  assign rd_addr = ADDR_W'({ax_r, step_r[1:0]});

  jplr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_cal_ram (
    .clk    (clk),
    .wr_en  (cmd.cal_wr),
    .wr_addr(cc_r),
    .wr_data(ib_byte_r),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign ax_last   = (ax_r == 2'(AXIS_COUNT - 1));
  assign step_last = (step_r == STEP_LAST);

  // setup: pick the side of the dead zone and the span
  always_comb begin
    if (ax_last) a_sel = last_r;
    else if (ax_r == 2'd0) a_sel = hold0_r;
    else a_sel = hold1_r;
    below   = a_sel < cal_sh_r[0];
    above   = a_sel > cal_sh_r[1];
    num     = below ? cal_sh_r[0] - a_sel : a_sel - cal_sh_r[1];
    den     = below ? {1'b0, cal_sh_r[0]} - {1'b0, cal_sh_r[2]}
                    : {1'b0, cal_sh_r[3]} - {1'b0, cal_sh_r[1]};
    den_neg = den[8];
    den_mag = den_neg ? 8'(9'd0 - den) : den[7:0];
    div_prod = 18'({10'd0, den_mag} * {8'd0, SPAN_SCALE});
  end

  // one restoring divide step per cycle
  always_comb begin
    rem2  = {rem_r, 1'b0};
    q_bit = rem2 >= {1'b0, div_r};
    q_fin = {q_r[30:0], q_bit};
    if (dead_r) val = '0;
    else if (zero_r) val = neg_r ? 32'd0 - AXIS_LIMIT : AXIS_LIMIT;
    else val = neg_r ? 32'd0 - q_fin : q_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ax_r   <= 2'd0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.calc_start) begin
        busy_r <= 1'b1;
        ax_r   <= 2'd0;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_last) begin
          step_r <= '0;
          if (ax_last) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            ax_r <= ax_r + 2'd1;
          end
        end else begin
          step_r <= step_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_start) begin
      for (int i = 0; i < AXES_MAX; i++) ax_val_r[i] <= '0;
      fault_r <= 1'b0;
    end else if (busy_r) begin
      if (step_r >= 6'd1 && step_r <= 6'd4) begin
        cal_sh_r[0] <= cal_sh_r[1];
        cal_sh_r[1] <= cal_sh_r[2];
        cal_sh_r[2] <= cal_sh_r[3];
        cal_sh_r[3] <= rd_data;
      end
      if (step_r == STEP_SETUP) begin
        div_r  <= div_prod;
        rem_r  <= {10'd0, num};
        neg_r  <= below ^ den_neg;
        dead_r <= !below && !above;
        zero_r <= (den_mag == 8'd0);
      end else if (step_r > STEP_SETUP) begin
        rem_r <= q_bit ? rem2[17:0] - div_r : rem2[17:0];
        q_r   <= q_fin;
      end
      if (step_last) begin
        ax_val_r[ax_r] <= val;
        if (!dead_r && zero_r) fault_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r   <= cmd.out_kind;
      out_tx_r     <= cmd.out_tx;
      out_rvalid_r <= cmd.out_rvalid;
      out_motor_r  <= cmd.out_motor;
      out_fault_r  <= cmd.out_frame & fault_r;
      out_x_r      <= cmd.out_frame ? ax_val_r[0] : '0;
      out_y_r      <= cmd.out_frame ? ax_val_r[1] : '0;
      out_z_r      <= cmd.out_frame ? ax_val_r[2] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_tx_byte       = out_tx_r;
  assign out_axis_x        = out_x_r;
  assign out_axis_y        = out_y_r;
  assign out_axis_z        = out_z_r;
  assign out_reading_valid = out_rvalid_r;
  assign out_motor_group   = out_motor_r;
  assign out_span_fault    = out_fault_r;

  assign stat.item_valid = ib_valid_r;
  assign stat.item_op    = ib_op_r;
  assign stat.byte_cmd   = (ib_byte_r == {6'd0, CMD_RECAL}) || (ib_byte_r == {6'd0, CMD_MOTOR});
  assign stat.byte_frame = ib_byte_r >= FRAME_MIN;
  assign stat.byte_low   = ib_byte_r[1:0];
  assign stat.cap_last   = (cc_r == ADDR_W'(DEPTH - 1));
  assign stat.frame_last = (cc_r == ADDR_W'(AXIS_COUNT - 1));
  assign stat.out_full   = out_valid_r;
  assign stat.calc_done  = done_r;

endmodule

FILE: hw/rtl/joystick_panel_link_receiver_top.sv
// Top level of the joystick panel link receiver.
//
//   channel | ports               | beat
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_ready | op, rx_byte: one poll or one received byte
//   out     | out_valid/out_ready | kind, tx_byte, axis_x/y/z, reading_valid,
//           |                     | motor_group, span_fault
//
// A beat lands in a one-entry input buffer and is handled once the scaler is idle and no
// result waits on out_ready. The last byte of an axis frame starts the scaler: per axis
// four calibration RAM reads, a setup step and 32 steps of the shared restoring divider.
// Reset is synchronous with no clearing pass; the calibration RAM holds nothing until
// the first capture. One input beat is buffered while a result waits on out_ready.
module joystick_panel_link_receiver_top import jplr_pkg::*; #(
  parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [1:0]         out_tx_byte,
  output logic signed [31:0] out_axis_x,
  output logic signed [31:0] out_axis_y,
  output logic signed [31:0] out_axis_z,
  output logic               out_reading_valid,
  output logic [1:0]         out_motor_group,
  output logic               out_span_fault
);

  jplr_cmd_t  cmd;
  jplr_stat_t stat;

  jplr_ctrl #(
    .AXIS_COUNT(AXIS_COUNT)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .cmd  (cmd)
  );

  jplr_dp #(
    .AXIS_COUNT(AXIS_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tx_byte      (out_tx_byte),
    .out_axis_x       (out_axis_x),
    .out_axis_y       (out_axis_y),
    .out_axis_z       (out_axis_z),
    .out_reading_valid(out_reading_valid),
    .out_motor_group  (out_motor_group),
    .out_span_fault   (out_span_fault),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule
